[rtl/lrbs_pkg.sv]
// Shared types, codes and constants for the link re-attach backoff supervisor.
`timescale 1ns / 1ps

package lrbs_pkg;

	// Event codes carried on the input tuser.
	typedef enum logic [1:0] {
		FUNC_TICK     = 2'd0,
		FUNC_ARM      = 2'd1,
		FUNC_DISABLE  = 2'd2,
		FUNC_IDENTITY = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_BACKOFF = 2'd1,
		MODE_PROBING = 2'd2
	} mode_t;

	// Register byte addresses on the configuration port.
	localparam int unsigned ADDR_W = 4;
	localparam logic [ADDR_W-1:0] ADDR_FIRST_BACKOFF = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_MAX_BACKOFF   = 4'h4;
	localparam logic [ADDR_W-1:0] ADDR_HAS_POWER_PIN = 4'h8;

	localparam logic [29:0] FIRST_BACKOFF_RST = 30'd5000;
	localparam logic [30:0] MAX_BACKOFF_RST   = 31'd60000;

	localparam logic [31:0] WINDOW_WITH_PIN = 32'd2500;
	localparam logic [31:0] WINDOW_NO_PIN   = 32'd4000;
	localparam logic [31:0] REQUEST_PERIOD  = 32'd300;

	localparam logic [7:0] ATTEMPTS_MAX = 8'd255;

	typedef struct packed {
		logic [29:0] first_backoff_ms;
		logic [30:0] max_backoff_ms;
		logic        has_power_pin;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  attempt_count;
		logic [30:0] backoff;
		logic [31:0] retry_at;
		logic [31:0] probe_deadline;
		logic [31:0] next_request_at;
		logic        link_open;
		logic        peer_alive;
		logic        peer_incompatible;
		logic        reply_seen;
		logic        power;
	} state_t;

	typedef struct packed {
		logic        power_on;
		logic        request_identity;
		logic        flush_input;
		logic        attached;
		logic        gave_up;
	} pulse_t;

	// Wrap-safe "now is at or past at".
	function automatic logic time_reached(input logic [31:0] now, input logic [31:0] at);
		logic [31:0] diff;
		diff = now - at;
		return ~diff[31];
	endfunction

endpackage

[rtl/lrbs_core.sv]
// Next-state and result logic for one event of the re-attach supervisor.
`timescale 1ns / 1ps

module lrbs_core (
	input  lrbs_pkg::cfg_t   cfg,
	input  lrbs_pkg::state_t st,
	input  lrbs_pkg::func_t  func,
	input  logic [31:0]      now_ms,
	input  logic             link_ok,
	input  logic             frame_is_reply,
	input  logic             frame_compatible,
	output lrbs_pkg::state_t st_next,
	output lrbs_pkg::pulse_t pulses
);

	logic [31:0] dbl;
	logic [31:0] grown;
	logic [30:0] capped;
	logic [30:0] arm_delay;
	logic [31:0] arm_at;
	logic        retry_due;
	logic        req_due;
	logic        deadline_due;

	// Delay for a re-arm: first value on a fresh start, else double and cap.
	assign dbl    = {st.backoff, 1'b0};
	assign grown  = (st.backoff == '0) ? {2'b00, cfg.first_backoff_ms} : dbl;
	assign capped = (grown > {1'b0, cfg.max_backoff_ms}) ? cfg.max_backoff_ms : grown[30:0];
	assign arm_delay = (st.mode == lrbs_pkg::MODE_OFF && st.attempt_count == '0)
		? {1'b0, cfg.first_backoff_ms} : capped;
	assign arm_at = now_ms + {1'b0, arm_delay};

	assign retry_due    = lrbs_pkg::time_reached(now_ms, st.retry_at);
	assign req_due      = lrbs_pkg::time_reached(now_ms, st.next_request_at);
	assign deadline_due = lrbs_pkg::time_reached(now_ms, st.probe_deadline);

	always_comb begin
		st_next = st;
		pulses  = '0;
		unique case (func)
			lrbs_pkg::FUNC_ARM: begin
				st_next.peer_alive = 1'b0;
				st_next.power      = 1'b0;
				st_next.link_open  = link_ok;
				st_next.backoff    = arm_delay;
				st_next.retry_at   = arm_at;
				st_next.mode       = lrbs_pkg::MODE_BACKOFF;
			end
			lrbs_pkg::FUNC_DISABLE: begin
				st_next.peer_alive = 1'b0;
				st_next.power      = 1'b0;
				st_next.mode       = lrbs_pkg::MODE_OFF;
			end
			lrbs_pkg::FUNC_IDENTITY: begin
				if (!frame_compatible) begin
					st_next.peer_alive        = 1'b0;
					st_next.peer_incompatible = 1'b1;
				end else begin
					st_next.peer_alive = 1'b1;
					if (frame_is_reply) begin
						st_next.reply_seen = 1'b1;
					end
				end
			end
			lrbs_pkg::FUNC_TICK: begin
				unique case (st.mode)
					lrbs_pkg::MODE_BACKOFF: begin
						if (retry_due) begin
							if (st.attempt_count != lrbs_pkg::ATTEMPTS_MAX) begin
								st_next.attempt_count = st.attempt_count + 8'd1;
							end
							if (!st.link_open && !link_ok) begin
								// open failed: stay unpowered, wait longer
								st_next.power    = 1'b0;
								st_next.backoff  = arm_delay;
								st_next.retry_at = arm_at;
								st_next.mode     = lrbs_pkg::MODE_BACKOFF;
							end else begin
								if (cfg.has_power_pin) begin
									st_next.power = 1'b1;
								end
								st_next.link_open         = 1'b1;
								st_next.peer_alive        = 1'b0;
								st_next.peer_incompatible = 1'b0;
								st_next.reply_seen        = 1'b0;
								pulses.flush_input        = 1'b1;
								st_next.probe_deadline    = now_ms + (cfg.has_power_pin
									? lrbs_pkg::WINDOW_WITH_PIN : lrbs_pkg::WINDOW_NO_PIN);
								st_next.next_request_at   = now_ms;
								st_next.mode              = lrbs_pkg::MODE_PROBING;
							end
						end
					end
					lrbs_pkg::MODE_PROBING: begin
						if (req_due) begin
							pulses.request_identity = 1'b1;
							st_next.next_request_at = now_ms + lrbs_pkg::REQUEST_PERIOD;
						end
						priority if (st.peer_alive && st.reply_seen) begin
							pulses.attached       = 1'b1;
							st_next.mode          = lrbs_pkg::MODE_OFF;
							st_next.attempt_count = '0;
							st_next.backoff       = '0;
						end else if (st.peer_incompatible) begin
							st_next.power  = 1'b0;
							pulses.gave_up = 1'b1;
							st_next.mode   = lrbs_pkg::MODE_OFF;
						end else if (deadline_due) begin
							st_next.power    = 1'b0;
							st_next.backoff  = arm_delay;
							st_next.retry_at = arm_at;
							st_next.mode     = lrbs_pkg::MODE_BACKOFF;
						end else begin
							// window still open: keep probing
						end
					end
					default: begin
						// off: ticks change nothing
					end
				endcase
			end
			default: begin
			end
		endcase
		pulses.power_on = st_next.power;
	end

endmodule

[rtl/link_reattach_backoff_supervisor.sv]
// Top level of the link re-attach backoff supervisor: stream ports, config and state.
`timescale 1ns / 1ps

// Takes one event transfer per clock while the output side keeps up and returns
// exactly one result transfer per event. Events go into an input register, the
// next-state logic of lrbs_core updates the supervisor state and fills the
// result register once the output side is free, so a new event may follow in
// every cycle while the output keeps up; the single state update stage sets that
// one-per-clock figure. The result register lets the input keep flowing while
// one finished result waits on m_axis_tready; with both registers full and the
// output stalled, s_axis_tready drops. Event codes on s_axis_tuser are tick,
// arm after failure, disable and identity frame. Time stamps are wrapping
// milliseconds; all deadline checks use the signed difference. Config registers
// (first delay, delay cap, power pin present) must be written over the APB port
// only while no event is in flight; the block itself does not enforce this.

module link_reattach_backoff_supervisor (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] now_ms, [32] link_ok, [33] frame_is_reply, [34] frame_compatible
	input  logic [39:0] s_axis_tdata,
	// [1:0] func
	input  logic [1:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] power_on, [1] request_identity, [2] flush_input, [3] attached,
	// [4] gave_up, [6:5] mode, [14:7] attempts, [45:15] backoff_ms
	output logic [47:0] m_axis_tdata,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lrbs_pkg::cfg_t   cfg_q;
	lrbs_pkg::state_t st_q;
	lrbs_pkg::state_t st_next;
	lrbs_pkg::pulse_t pulses;

	// input register
	logic             valid_s1;
	lrbs_pkg::func_t  func_s1;
	logic [31:0]      now_s1;
	logic             link_ok_s1;
	logic             reply_s1;
	logic             compat_s1;

	// result register
	logic             valid_s2;
	logic [47:0]      data_s2;

	logic out_free;
	logic advance;
	logic cfg_wr;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_backoff_ms <= lrbs_pkg::FIRST_BACKOFF_RST;
			cfg_q.max_backoff_ms   <= lrbs_pkg::MAX_BACKOFF_RST;
			cfg_q.has_power_pin    <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr)
				lrbs_pkg::ADDR_FIRST_BACKOFF: cfg_q.first_backoff_ms <= pwdata[29:0];
				lrbs_pkg::ADDR_MAX_BACKOFF:   cfg_q.max_backoff_ms   <= pwdata[30:0];
				lrbs_pkg::ADDR_HAS_POWER_PIN: cfg_q.has_power_pin    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			lrbs_pkg::ADDR_FIRST_BACKOFF: prdata = {2'b00, cfg_q.first_backoff_ms};
			lrbs_pkg::ADDR_MAX_BACKOFF:   prdata = {1'b0, cfg_q.max_backoff_ms};
			lrbs_pkg::ADDR_HAS_POWER_PIN: prdata = {31'd0, cfg_q.has_power_pin};
			default:                      prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1    <= lrbs_pkg::func_t'(s_axis_tuser);
			now_s1     <= s_axis_tdata[31:0];
			link_ok_s1 <= s_axis_tdata[32];
			reply_s1   <= s_axis_tdata[33];
			compat_s1  <= s_axis_tdata[34];
		end
	end

	// ---------------- state update ----------------
	lrbs_core u_core (
		.cfg              (cfg_q),
		.st               (st_q),
		.func             (func_s1),
		.now_ms           (now_s1),
		.link_ok          (link_ok_s1),
		.frame_is_reply   (reply_s1),
		.frame_compatible (compat_s1),
		.st_next          (st_next),
		.pulses           (pulses)
	);

	// State only moves when the event moves into the result register.
	// All-zero state is mode off with every count and flag cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {2'b00, st_next.backoff, st_next.attempt_count, st_next.mode,
				pulses.gave_up, pulses.attached, pulses.flush_input,
				pulses.request_identity, pulses.power_on};
		end
	end

	// ---------------- checks ----------------
	// flush, attach and give-up come from different modes and never coincide
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tdata[4:2]))
		else $error("exclusive result pulses overlap");

	// an attach clears the attempt count and leaves the block off
	a_attach_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3]) |->
			(m_axis_tdata[6:5] == lrbs_pkg::MODE_OFF && m_axis_tdata[14:7] == 8'd0))
		else $error("attach result without cleared state");

	// a flush always starts a probing phase
	a_flush_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[6:5] == lrbs_pkg::MODE_PROBING)
		else $error("flush outside of probe start");

	// a held event with a stalled result must block new input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while both stages are held");

endmodule

[test/link_reattach_backoff_supervisor_tb.sv]
// Self-checking testbench for the link re-attach backoff supervisor.
`timescale 1ns / 1ps

// Event transfers go in on the slave stream. Each accepted transfer is run through
// a behavioral copy of the supervisor kept in this module. That copy holds the
// mode, the attempt count, the delay, the deadlines and the peer flags, and it
// yields the one status word that the event must produce. A monitor compares each
// status transfer on the master stream, field by field, against the oldest
// pending prediction.
// Test order: directed events, zero delay with the attempt count hitting its
// ceiling, delay doubling against the cap, a long output stall that backs up the
// input, and constrained-random sessions under several register settings. The
// last of those settings runs with no idle cycles on either side.
module link_reattach_backoff_supervisor_tb;

	localparam int unsigned CYCLE_LIMIT     = 500000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned EVENTS_PER_SET  = 240;

	// Status word as it appears on the master stream.
	typedef struct {
		logic              power_on;
		logic              request_identity;
		logic              flush_input;
		logic              attached;
		logic              gave_up;
		lrbs_pkg::mode_t   mode;
		logic [7:0]        attempts;
		logic [30:0]       backoff_ms;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// [31:0] now_ms, [32] link_ok, [33] frame_is_reply, [34] frame_compatible
	logic [39:0] s_axis_tdata;
	// [1:0] func
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [0] power_on, [1] request_identity, [2] flush_input, [3] attached,
	// [4] gave_up, [6:5] mode, [14:7] attempts, [45:15] backoff_ms
	logic [47:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predicted supervisor state and register copies.
	lrbs_pkg::mode_t sup_mode;
	logic [7:0]  sup_attempts;
	logic [30:0] sup_delay;
	logic [31:0] sup_retry_at;
	logic [31:0] sup_deadline;
	logic [31:0] sup_next_req;
	logic        sup_link_open;
	logic        sup_alive;
	logic        sup_incompat;
	logic        sup_reply;
	logic        sup_power;
	logic [29:0] cfg_first;
	logic [30:0] cfg_max;
	logic        cfg_pin;

	status_t     expected_status[$];
	logic [31:0] clock_ms;         // last time stamp sent
	bit          quiet_phase;      // no idle cycles on either side
	bit          hold_off_req;     // asks the receiver for one long stall
	int unsigned cycle_count;
	int unsigned errors;
	int unsigned n_events, n_flush, n_requests, n_attach, n_gave_up, n_ceiling, n_settings;

	link_reattach_backoff_supervisor i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Wrap-safe: true when now is at or past the stamp.
	function automatic bit time_due(input logic [31:0] now, input logic [31:0] stamp);
		logic [31:0] gap;
		gap = now - stamp;
		return gap[31] == 1'b0;
	endfunction

	// Pick the next retry delay and enter backoff. The very first delay after an
	// attach (or after reset) is taken as is; later ones double and are capped.
	function automatic void schedule_retry(input logic [31:0] now);
		logic [31:0] next_delay;
		if (sup_mode == lrbs_pkg::MODE_OFF && sup_attempts == 8'd0) begin
			sup_delay = {1'b0, cfg_first};
		end else begin
			next_delay = (sup_delay == 31'd0) ? {2'b00, cfg_first} : {sup_delay, 1'b0};
			if (next_delay > {1'b0, cfg_max})
				next_delay = {1'b0, cfg_max};
			sup_delay = next_delay[30:0];
		end
		sup_retry_at = now + {1'b0, sup_delay};
		sup_mode = lrbs_pkg::MODE_BACKOFF;
	endfunction

	function automatic status_t advance_supervisor(input lrbs_pkg::func_t f,
			input logic [31:0] now, input logic lok, input logic rep, input logic comp);
		status_t res;
		res.request_identity = 1'b0;
		res.flush_input      = 1'b0;
		res.attached         = 1'b0;
		res.gave_up          = 1'b0;
		case (f)
		lrbs_pkg::FUNC_ARM: begin
			sup_alive = 1'b0;
			sup_power = 1'b0;
			sup_link_open = lok;
			schedule_retry(now);
		end
		lrbs_pkg::FUNC_DISABLE: begin
			sup_alive = 1'b0;
			sup_power = 1'b0;
			sup_mode = lrbs_pkg::MODE_OFF;
		end
		lrbs_pkg::FUNC_IDENTITY: begin
			if (!comp) begin
				sup_alive = 1'b0;
				sup_incompat = 1'b1;
			end else begin
				sup_alive = 1'b1;
				if (rep)
					sup_reply = 1'b1;
			end
		end
		lrbs_pkg::FUNC_TICK: begin
			if (sup_mode == lrbs_pkg::MODE_BACKOFF) begin
				if (time_due(now, sup_retry_at)) begin
					if (sup_attempts != lrbs_pkg::ATTEMPTS_MAX)
						sup_attempts++;
					if (cfg_pin)
						sup_power = 1'b1;
					if (!sup_link_open && !lok) begin
						// open failed: unpower and back off again
						sup_power = 1'b0;
						schedule_retry(now);
					end else begin
						sup_link_open = 1'b1;
						sup_alive = 1'b0;
						sup_incompat = 1'b0;
						sup_reply = 1'b0;
						res.flush_input = 1'b1;
						sup_deadline = now + (cfg_pin ? lrbs_pkg::WINDOW_WITH_PIN
							: lrbs_pkg::WINDOW_NO_PIN);
						sup_next_req = now;
						sup_mode = lrbs_pkg::MODE_PROBING;
					end
				end
			end else if (sup_mode == lrbs_pkg::MODE_PROBING) begin
				if (time_due(now, sup_next_req)) begin
					res.request_identity = 1'b1;
					sup_next_req = now + lrbs_pkg::REQUEST_PERIOD;
				end
				if (sup_alive && sup_reply) begin
					res.attached = 1'b1;
					sup_mode = lrbs_pkg::MODE_OFF;
					sup_attempts = 8'd0;
					sup_delay = 31'd0;
				end else if (sup_incompat) begin
					sup_power = 1'b0;
					res.gave_up = 1'b1;
					sup_mode = lrbs_pkg::MODE_OFF;
				end else if (time_due(now, sup_deadline)) begin
					sup_power = 1'b0;
					schedule_retry(now);
				end
			end
		end
		default: begin
		end
		endcase
		res.power_on   = sup_power;
		res.mode       = sup_mode;
		res.attempts   = sup_attempts;
		res.backoff_ms = sup_delay;
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	function automatic void report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		errors++;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endfunction

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	// One event transfer. Valid stays high afterwards so that a following call
	// can go back to back; wait_idle drops it.
	task automatic send_event(input lrbs_pkg::func_t f, input logic [31:0] now,
			input logic lok, input logic rep, input logic comp);
		status_t want;
		@(negedge clk);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= f;
		s_axis_tdata  <= {5'b00000, comp, rep, lok, now};
		do @(posedge clk); while (!s_axis_tready);
		clock_ms = now;
		want = advance_supervisor(f, now, lok, rep, comp);
		expected_status.push_back(want);
		n_events++;
		n_flush    += 32'(want.flush_input);
		n_requests += 32'(want.request_identity);
		n_attach   += 32'(want.attached);
		n_gave_up  += 32'(want.gave_up);
		n_ceiling  += 32'(want.attempts == lrbs_pkg::ATTEMPTS_MAX);
	endtask

	// Stop offering and wait until every predicted status has come back.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// Register write followed by a read-back of the masked value.
	task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
		logic [31:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
		lrbs_pkg::ADDR_FIRST_BACKOFF: cfg_first = value[29:0];
		lrbs_pkg::ADDR_MAX_BACKOFF:   cfg_max   = value[30:0];
		default:                      cfg_pin   = value[0];
		endcase
		want = (addr == lrbs_pkg::ADDR_FIRST_BACKOFF) ? {2'b00, cfg_first} :
		       (addr == lrbs_pkg::ADDR_MAX_BACKOFF)   ? {1'b0, cfg_max} : {31'd0, cfg_pin};
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch("register read-back", want, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random event shaped by the predicted mode: mostly ticks aimed at the
	// retry time and probing traffic, with some noise at random times.
	task automatic send_random_event();
		int unsigned roll;
		logic [31:0] now;
		logic        lok, rep, comp;
		roll = $urandom_range(0, 99);
		lok  = ($urandom_range(0, 3) != 0);
		rep  = 1'($urandom_range(0, 1));
		comp = ($urandom_range(0, 9) != 0);
		now  = clock_ms + $urandom_range(0, 50);
		if (roll < 4) begin
			send_event(lrbs_pkg::func_t'($urandom_range(0, 3)), $urandom(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (sup_mode == lrbs_pkg::MODE_BACKOFF) begin
			if (roll < 64)
				send_event(lrbs_pkg::FUNC_TICK, sup_retry_at + $urandom_range(0, 4) - 32'd2,
					lok, rep, comp);
			else if (roll < 80)
				send_event(lrbs_pkg::FUNC_TICK, now, lok, rep, comp);
			else if (roll < 90)
				send_event(lrbs_pkg::FUNC_IDENTITY, now, lok, rep, comp);
			else if (roll < 95)
				send_event(lrbs_pkg::FUNC_ARM, now, lok, rep, comp);
			else
				send_event(lrbs_pkg::FUNC_DISABLE, now, lok, rep, comp);
		end else if (sup_mode == lrbs_pkg::MODE_PROBING) begin
			if (roll < 50)
				send_event(lrbs_pkg::FUNC_TICK, clock_ms + $urandom_range(0, 400),
					lok, rep, comp);
			else if (roll < 58)
				send_event(lrbs_pkg::FUNC_TICK, sup_deadline + $urandom_range(0, 2) - 32'd1,
					lok, rep, comp);
			else if (roll < 90)
				send_event(lrbs_pkg::FUNC_IDENTITY, now, lok, (roll < 80) | rep, comp);
			else if (roll < 95)
				send_event(lrbs_pkg::FUNC_ARM, now, lok, rep, comp);
			else
				send_event(lrbs_pkg::FUNC_DISABLE, now, lok, rep, comp);
		end else begin
			if (roll < 75)
				send_event(lrbs_pkg::FUNC_ARM, now, lok, rep, comp);
			else if (roll < 88)
				send_event(lrbs_pkg::FUNC_TICK, now, lok, rep, comp);
			else if (roll < 96)
				send_event(lrbs_pkg::FUNC_IDENTITY, now, lok, rep, comp);
			else
				send_event(lrbs_pkg::FUNC_DISABLE, now, lok, rep, comp);
		end
	endtask

	// Status transfers are taken at the rising edge where valid and ready are high.
	always @(posedge clk) begin : status_monitor
		status_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.power_on         = m_axis_tdata[0];
			got.request_identity = m_axis_tdata[1];
			got.flush_input      = m_axis_tdata[2];
			got.attached         = m_axis_tdata[3];
			got.gave_up          = m_axis_tdata[4];
			got.mode             = lrbs_pkg::mode_t'(m_axis_tdata[6:5]);
			got.attempts         = m_axis_tdata[14:7];
			got.backoff_ms       = m_axis_tdata[45:15];
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t ns: status transfer with nothing expected, %s %h",
					$time, "expected none, actual", m_axis_tdata);
			end else begin
				want = expected_status.pop_front();
				if (got.power_on !== want.power_on)
					report_mismatch("power_on", 32'(want.power_on), 32'(got.power_on));
				if (got.request_identity !== want.request_identity)
					report_mismatch("request_identity", 32'(want.request_identity),
						32'(got.request_identity));
				if (got.flush_input !== want.flush_input)
					report_mismatch("flush_input", 32'(want.flush_input),
						32'(got.flush_input));
				if (got.attached !== want.attached)
					report_mismatch("attached", 32'(want.attached), 32'(got.attached));
				if (got.gave_up !== want.gave_up)
					report_mismatch("gave_up", 32'(want.gave_up), 32'(got.gave_up));
				if (got.mode !== want.mode)
					report_mismatch("mode", 32'(want.mode), 32'(got.mode));
				if (got.attempts !== want.attempts)
					report_mismatch("attempts", 32'(want.attempts), 32'(got.attempts));
				if (got.backoff_ms !== want.backoff_ms)
					report_mismatch("backoff_ms", 32'(want.backoff_ms),
						32'(got.backoff_ms));
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none in the
	// quiet phase.
	initial begin : status_receiver
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b0;
				for (int c = 0; c < HOLD_OFF_CYCLES; c++)
					@(negedge clk);
			end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: run timed out after %0d cycles", $time, cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Every event kind, pulses, the wrap of the ms counter and the probe window,
	// with the register values from reset.
	task automatic test_directed_events();
		send_event(lrbs_pkg::FUNC_TICK, 32'd0, 1'b1, 1'b0, 1'b0);          // off: ignored
		send_event(lrbs_pkg::FUNC_ARM, 32'd100, 1'b0, 1'b0, 1'b0);         // first delay
		send_event(lrbs_pkg::FUNC_TICK, 32'd5099, 1'b0, 1'b0, 1'b0);       // one ms early
		send_event(lrbs_pkg::FUNC_TICK, 32'd5100, 1'b0, 1'b0, 1'b0);       // open fails
		send_event(lrbs_pkg::FUNC_IDENTITY, 32'd5200, 1'b0, 1'b0, 1'b0);   // incompatible
		send_event(lrbs_pkg::FUNC_TICK, 32'd15100, 1'b1, 1'b0, 1'b0);      // open ok: probe
		send_event(lrbs_pkg::FUNC_TICK, 32'd15100, 1'b0, 1'b0, 1'b0);      // request at once
		send_event(lrbs_pkg::FUNC_TICK, 32'd15399, 1'b0, 1'b0, 1'b0);      // not yet due
		send_event(lrbs_pkg::FUNC_IDENTITY, 32'd15450, 1'b0, 1'b1, 1'b1);  // compatible reply
		send_event(lrbs_pkg::FUNC_TICK, 32'd15500, 1'b0, 1'b0, 1'b0);      // request, attach
		send_event(lrbs_pkg::FUNC_ARM, 32'hFFFF_F000, 1'b1, 1'b1, 1'b1);   // near wrap
		send_event(lrbs_pkg::FUNC_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);  // before stamp
		send_event(lrbs_pkg::FUNC_TICK, 32'h0000_0388, 1'b0, 1'b0, 1'b0);  // due after wrap
		send_event(lrbs_pkg::FUNC_IDENTITY, 32'h0000_0390, 1'b0, 1'b0, 1'b1); // boot frame
		send_event(lrbs_pkg::FUNC_TICK, 32'h0000_03F0, 1'b0, 1'b0, 1'b0);  // alive, no reply
		send_event(lrbs_pkg::FUNC_IDENTITY, 32'h0000_0400, 1'b0, 1'b1, 1'b0); // incompatible
		send_event(lrbs_pkg::FUNC_TICK, 32'h0000_0450, 1'b0, 1'b0, 1'b0);  // give up
		send_event(lrbs_pkg::FUNC_DISABLE, 32'h0000_0500, 1'b1, 1'b1, 1'b1);
		send_event(lrbs_pkg::FUNC_ARM, 32'h0000_0600, 1'b1, 1'b0, 1'b0);   // doubles
		send_event(lrbs_pkg::FUNC_TICK, 32'd11536, 1'b0, 1'b0, 1'b0);      // probe, link open
		send_event(lrbs_pkg::FUNC_TICK, 32'd14035, 1'b0, 1'b0, 1'b0);      // window edge - 1
		send_event(lrbs_pkg::FUNC_TICK, 32'd14036, 1'b0, 1'b0, 1'b0);      // re-arm
	endtask

	// First delay of zero keeps every retry due at once; the attempt count
	// must stop at its ceiling. No power pin: 4000 ms window, power stays low.
	task automatic test_zero_delay_saturation();
		logic [31:0] probe_start;
		wait_idle();
		write_reg(lrbs_pkg::ADDR_FIRST_BACKOFF, 32'd0);
		write_reg(lrbs_pkg::ADDR_MAX_BACKOFF, 32'd1);
		write_reg(lrbs_pkg::ADDR_HAS_POWER_PIN, 32'd0);
		send_event(lrbs_pkg::FUNC_ARM, 32'd50000, 1'b0, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_TICK, sup_retry_at, 1'b1, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_IDENTITY, clock_ms + 10, 1'b0, 1'b1, 1'b1);
		send_event(lrbs_pkg::FUNC_TICK, clock_ms + 10, 1'b0, 1'b0, 1'b0); // attach clears
		send_event(lrbs_pkg::FUNC_ARM, clock_ms + 10, 1'b0, 1'b0, 1'b0);  // delay zero
		repeat (260)
			send_event(lrbs_pkg::FUNC_TICK, clock_ms + $urandom_range(0, 3),
				1'b0, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_TICK, clock_ms, 1'b1, 1'b0, 1'b0);
		probe_start = clock_ms;
		send_event(lrbs_pkg::FUNC_TICK, probe_start + lrbs_pkg::WINDOW_NO_PIN - 32'd1,
			1'b0, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_TICK, probe_start + lrbs_pkg::WINDOW_NO_PIN,
			1'b0, 1'b0, 1'b0);
	endtask

	// Largest delays: doubling must saturate at the cap, and the very first
	// delay after an attach is not capped.
	task automatic test_delay_cap();
		wait_idle();
		write_reg(lrbs_pkg::ADDR_FIRST_BACKOFF, 32'hFFFF_FFFF);
		write_reg(lrbs_pkg::ADDR_MAX_BACKOFF, 32'hFFFF_FFFF);
		write_reg(lrbs_pkg::ADDR_HAS_POWER_PIN, 32'hFFFF_FFFF);
		send_event(lrbs_pkg::FUNC_ARM, clock_ms + 10, 1'b0, 1'b0, 1'b0);
		repeat (4)
			send_event(lrbs_pkg::FUNC_TICK, sup_retry_at, 1'b0, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_TICK, sup_retry_at, 1'b1, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_IDENTITY, clock_ms + 1, 1'b0, 1'b1, 1'b1);
		send_event(lrbs_pkg::FUNC_TICK, clock_ms + 1, 1'b0, 1'b0, 1'b0);
		wait_idle();
		write_reg(lrbs_pkg::ADDR_MAX_BACKOFF, 32'd1);
		send_event(lrbs_pkg::FUNC_ARM, clock_ms + 5, 1'b0, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_TICK, sup_retry_at, 1'b0, 1'b0, 1'b0);
		send_event(lrbs_pkg::FUNC_TICK, sup_retry_at, 1'b0, 1'b0, 1'b0);
	endtask

	// Output held off for a long stretch while events keep coming, so the
	// block fills up and drops s_axis_tready.
	task automatic test_output_backpressure();
		wait_idle();
		hold_off_req = 1'b1;
		repeat (40)
			send_random_event();
	endtask

	task automatic test_random_traffic();
		logic [31:0] first_v, max_v, pin_v;
		for (int s = 0; s < 5; s++) begin
			case (s)
			0: begin
				first_v = $urandom_range(1, 20000);
				max_v   = first_v + $urandom_range(0, 200000);
				pin_v   = $urandom_range(0, 1);
			end
			1: begin
				first_v = 32'd1;
				max_v   = 32'd1;
				pin_v   = 32'd0;
			end
			2: begin
				first_v = 32'h3FFF_FFFF;
				max_v   = 32'h7FFF_FFFF;
				pin_v   = 32'd1;
			end
			3: begin
				first_v = 32'd0;
				max_v   = $urandom_range(1, 50000);
				pin_v   = 32'd1;
			end
			default: begin
				// reset values, and no idle cycles from here on
				first_v = 32'd5000;
				max_v   = 32'd60000;
				pin_v   = 32'd1;
				quiet_phase = 1'b1;
			end
			endcase
			wait_idle();
			write_reg(lrbs_pkg::ADDR_FIRST_BACKOFF, first_v);
			write_reg(lrbs_pkg::ADDR_MAX_BACKOFF, max_v);
			write_reg(lrbs_pkg::ADDR_HAS_POWER_PIN, pin_v);
			n_settings++;
			repeat (EVENTS_PER_SET)
				send_random_event();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= lrbs_pkg::FUNC_TICK;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		// prediction starts from the reset state
		sup_mode      = lrbs_pkg::MODE_OFF;
		sup_attempts  = '0;
		sup_delay     = '0;
		sup_retry_at  = '0;
		sup_deadline  = '0;
		sup_next_req  = '0;
		sup_link_open = 1'b0;
		sup_alive     = 1'b0;
		sup_incompat  = 1'b0;
		sup_reply     = 1'b0;
		sup_power     = 1'b0;
		cfg_first     = lrbs_pkg::FIRST_BACKOFF_RST;
		cfg_max       = lrbs_pkg::MAX_BACKOFF_RST;
		cfg_pin       = 1'b1;
		clock_ms      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_zero_delay_saturation();
		test_delay_cap();
		test_output_backpressure();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d events over %0d random register settings plus directed ones:",
			n_events, n_settings);
		$display("%0d flushes, %0d identity requests, %0d attaches, %0d give-ups,",
			n_flush, n_requests, n_attach, n_gave_up);
		$display("%0d results at the attempt ceiling", n_ceiling);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[link_reattach_backoff_supervisor.f]
rtl/lrbs_pkg.sv
rtl/lrbs_core.sv
rtl/link_reattach_backoff_supervisor.sv
test/link_reattach_backoff_supervisor_tb.sv
